@@ hdl/pvq_pkg.sv @@
// ----------------------------------------------------------------------------
// pvq_pkg
// Shared types and constants for the palette vector quantizer: color layout,
// distance and index widths, palette geometry.
// ----------------------------------------------------------------------------
package pvq_pkg;

    // Palette geometry
    localparam int NUM_SLOTS        = 16;
    localparam int PAL_WORDS        = 4;
    localparam int ENTRIES_PER_WORD = NUM_SLOTS / PAL_WORDS;
    localparam int ENTRY_W          = 16;
    localparam int PAL_WORD_W       = ENTRY_W * ENTRIES_PER_WORD;
    localparam int PADDR_W          = 5;
    localparam int DEFAULT_ENTRIES  = 16;

    // Argmin tree geometry: groups in the first level, one pick in the second
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = NUM_SLOTS / GROUP_SIZE;

    // Datapath widths
    localparam int CH_W   = 5;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int IDX_W  = 4;

    // Larger than any real distance (3 * 31 * 31 = 2883), never wins
    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // RGB555: red 4:0, green 9:5, blue 14:10
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } color_t;

    // Absolute channel difference
    function automatic chan_t abs_diff(input chan_t a, input chan_t b);
        chan_t d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

@@ hdl/pvq_dist.sv @@
// ----------------------------------------------------------------------------
// pvq_dist
// Squared Euclidean distance from one pixel to every palette slot, in two
// register stages: per-channel squares, then the three-term sum.
// ----------------------------------------------------------------------------
module pvq_dist #(
    parameter int PALETTE_ENTRIES = pvq_pkg::DEFAULT_ENTRIES
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  pvq_pkg::color_t                             pix,
    input  pvq_pkg::color_t [pvq_pkg::NUM_SLOTS-1:0]    palette,
    output logic                                        out_valid,
    output pvq_pkg::dist_t  [pvq_pkg::NUM_SLOTS-1:0]    slot_dist
);
    import pvq_pkg::*;

    logic  sq_valid_reg;
    logic  sum_valid_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_SLOTS; k++)
        begin : g_slot
            if (k < PALETTE_ENTRIES)
            begin : g_live
                chan_t dr;
                chan_t dg;
                chan_t db;
                sq_t   sq_r_reg;
                sq_t   sq_g_reg;
                sq_t   sq_b_reg;
                dist_t dist_reg;

                assign dr = abs_diff(pix.red,   palette[k].red);
                assign dg = abs_diff(pix.green, palette[k].green);
                assign db = abs_diff(pix.blue,  palette[k].blue);

                // Square each channel difference
                always_ff @(posedge clk)
                begin
                    sq_r_reg <= {{CH_W{1'b0}}, dr} * {{CH_W{1'b0}}, dr};
                    sq_g_reg <= {{CH_W{1'b0}}, dg} * {{CH_W{1'b0}}, dg};
                    sq_b_reg <= {{CH_W{1'b0}}, db} * {{CH_W{1'b0}}, db};
                end

                // Sum the three squares
                always_ff @(posedge clk)
                begin
                    dist_reg <= {2'b00, sq_r_reg} + {2'b00, sq_g_reg}
                              + {2'b00, sq_b_reg};
                end

                assign slot_dist[k] = dist_reg;
            end
            else
            begin : g_unused
                // Slot outside the palette: hold a distance that never wins
                assign slot_dist[k] = DIST_NONE;
            end
        end
    endgenerate

    assign out_valid = sum_valid_reg;

endmodule

@@ hdl/pvq_argmin.sv @@
// ----------------------------------------------------------------------------
// pvq_argmin
// Index of the smallest distance over all palette slots, as a two-level
// registered tree. Strict compares keep the lowest index on a tie.
// ----------------------------------------------------------------------------
module pvq_argmin (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  pvq_pkg::dist_t  [pvq_pkg::NUM_SLOTS-1:0]    slot_dist,
    output logic                                        out_valid,
    output pvq_pkg::idx_t                               idx
);
    import pvq_pkg::*;

    logic  grp_valid_reg;
    logic  fin_valid_reg;
    dist_t grp_dist_next [NUM_GROUPS];
    idx_t  grp_idx_next  [NUM_GROUPS];
    dist_t grp_dist_reg  [NUM_GROUPS];
    idx_t  grp_idx_reg   [NUM_GROUPS];
    dist_t fin_dist;
    idx_t  idx_next;
    idx_t  idx_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= in_valid;
            fin_valid_reg <= grp_valid_reg;
        end
    end

    // First level: best slot within each group, scanned upward
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_dist_next[g] = slot_dist[g * GROUP_SIZE];
            grp_idx_next[g]  = IDX_W'(g * GROUP_SIZE);
            for (int j = 1; j < GROUP_SIZE; j++)
            begin
                if (slot_dist[g * GROUP_SIZE + j] < grp_dist_next[g])
                begin
                    grp_dist_next[g] = slot_dist[g * GROUP_SIZE + j];
                    grp_idx_next[g]  = IDX_W'(g * GROUP_SIZE + j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_dist_reg[g] <= grp_dist_next[g];
            grp_idx_reg[g]  <= grp_idx_next[g];
        end
    end

    // Second level: best group, lower group first
    always_comb
    begin
        fin_dist = grp_dist_reg[0];
        idx_next = grp_idx_reg[0];
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            if (grp_dist_reg[g] < fin_dist)
            begin
                fin_dist = grp_dist_reg[g];
                idx_next = grp_idx_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign out_valid = fin_valid_reg;
    assign idx       = idx_reg;

endmodule

@@ hdl/palette_vector_quantizer.sv @@
// ----------------------------------------------------------------------------
// palette_vector_quantizer
// Nearest-color quantization of two RGB555 pixels against a 16-entry palette,
// packing the odd pixel's index in bits 7:4 and the even pixel's in 3:0.
// ----------------------------------------------------------------------------
// Pipeline: done pulses once an accepted request has passed the register stages for
//   squares, sum, group minimum and final minimum.
// Throughput: one request per cycle; busy stays low, nothing stalls.
// Results cannot be held off: each is shown on packed_indices for one cycle.
// Reset (rst_n low, asynchronous): pipeline valid bits clear, palette reads 0.
// ----------------------------------------------------------------------------
module palette_vector_quantizer #(
    parameter int PALETTE_ENTRIES = pvq_pkg::DEFAULT_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel
    input  logic                                start,
    output logic                                busy,
    input  pvq_pkg::chan_t                      even_red,
    input  pvq_pkg::chan_t                      even_green,
    input  pvq_pkg::chan_t                      even_blue,
    input  pvq_pkg::chan_t                      odd_red,
    input  pvq_pkg::chan_t                      odd_green,
    input  pvq_pkg::chan_t                      odd_blue,
    // Result channel
    output logic                                done,
    output logic [7:0]                          packed_indices,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pvq_pkg::PADDR_W-1:0]         paddr,
    input  logic [pvq_pkg::PAL_WORD_W-1:0]      pwdata,
    output logic [pvq_pkg::PAL_WORD_W-1:0]      prdata,
    output logic                                pready
);
    import pvq_pkg::*;

    localparam int WSEL_W = $clog2(PAL_WORDS);
    localparam int WSEL_LSB = PADDR_W - WSEL_W;

    logic [PAL_WORD_W-1:0]   pal_word_reg [PAL_WORDS];
    logic [WSEL_W-1:0]       wsel;
    logic                    cfg_write;
    color_t [NUM_SLOTS-1:0]  palette;
    color_t                  even_pix;
    color_t                  odd_pix;
    logic                    accept;
    logic                    even_dvalid;
    logic                    odd_dvalid;
    dist_t [NUM_SLOTS-1:0]   even_dist;
    dist_t [NUM_SLOTS-1:0]   odd_dist;
    logic                    even_ovalid;
    logic                    odd_ovalid;
    idx_t                    even_idx;
    idx_t                    odd_idx;

    // Configuration registers, one 64-bit word per four entries
    assign pready    = 1'b1;
    assign wsel      = paddr[PADDR_W-1:WSEL_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PAL_WORDS; w++)
            begin
                pal_word_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            pal_word_reg[wsel] <= pwdata;
        end
    end

    assign prdata = pal_word_reg[wsel];

    // Split words into palette entries; the top bit of each entry is unused
    genvar k;
    generate
        for (k = 0; k < NUM_SLOTS; k++)
        begin : g_unpack
            assign palette[k] = color_t'(pal_word_reg[k / ENTRIES_PER_WORD]
                                [ENTRY_W * (k % ENTRIES_PER_WORD) +: $bits(color_t)]);
        end
    endgenerate

    // Take a request every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign even_pix = '{blue: even_blue, green: even_green, red: even_red};
    assign odd_pix  = '{blue: odd_blue,  green: odd_green,  red: odd_red};

    pvq_dist #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dist_even (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pix       (even_pix),
        .palette   (palette),
        .out_valid (even_dvalid),
        .slot_dist (even_dist)
    );

    pvq_dist #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dist_odd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pix       (odd_pix),
        .palette   (palette),
        .out_valid (odd_dvalid),
        .slot_dist (odd_dist)
    );

    pvq_argmin u_min_even (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (even_dvalid),
        .slot_dist (even_dist),
        .out_valid (even_ovalid),
        .idx       (even_idx)
    );

    pvq_argmin u_min_odd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (odd_dvalid),
        .slot_dist (odd_dist),
        .out_valid (odd_ovalid),
        .idx       (odd_idx)
    );

    // Both lanes run in lockstep
    assign done           = even_ovalid && odd_ovalid;
    assign packed_indices = {odd_idx, even_idx};

endmodule

@@ hdl/pvq_checker.sv @@
// ----------------------------------------------------------------------------
// pvq_checker
// Port-level checks for the palette vector quantizer: result timing against
// requests, index range, and register readback.
// ----------------------------------------------------------------------------
module pvq_checker #(
    parameter int PALETTE_ENTRIES = pvq_pkg::DEFAULT_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [7:0]                          packed_indices,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pvq_pkg::PADDR_W-1:0]         paddr,
    input  logic [pvq_pkg::PAL_WORD_W-1:0]      pwdata,
    input  logic [pvq_pkg::PAL_WORD_W-1:0]      prdata,
    input  logic                                pready
);
    import pvq_pkg::*;

    // Every result traces back to an accepted request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a matching request");

    // Every request accepted out of reset yields a result
    a_request_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy && rst_n, 4) && $past(rst_n, 3)
         && $past(rst_n, 2) && $past(rst_n, 1)) |-> done)
        else $error("request lost in the pipeline");

    // Indices stay within the configured palette
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((packed_indices[3:0] < PALETTE_ENTRIES)
                  && (packed_indices[7:4] < PALETTE_ENTRIES)))
        else $error("palette index beyond the configured entries");

    // A register read right after a write returns the written word
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(psel && penable && pwrite && pready) && psel && !pwrite
         && (paddr[PADDR_W-1:PADDR_W-2] == $past(paddr[PADDR_W-1:PADDR_W-2])))
        |-> (prdata == $past(pwdata)))
        else $error("palette register readback mismatch");

endmodule

bind palette_vector_quantizer pvq_checker #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_pvq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .packed_indices (packed_indices),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
);

@@ verif/palette_vector_quantizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_vector_quantizer_tb
// Self-checking bench for the palette quantizer. Palettes are loaded over the
// APB port while the pipeline is empty. Pixel pairs are then streamed with
// random sender gaps. Every packed index byte is compared with a
// nearest-color search that the bench runs on its own copy of the palette.
// ----------------------------------------------------------------------------
module palette_vector_quantizer_tb;
    import pvq_pkg::*;

    localparam int NUM_ENTRIES       = DEFAULT_ENTRIES;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int PAIRS_PER_PALETTE = 142;
    localparam int REG_STRIDE        = 8;

    typedef struct packed {
        color_t odd;
        color_t even;
    } pixel_pair_t;

    // Nearest-color predictor and in-order store of expected index bytes
    class palette_index_checker;
        logic [PAL_WORD_W-1:0] pal_word [PAL_WORDS];
        logic [7:0]            pending_indices [$];
        int                    mismatches;
        int                    checked;

        function new();
            foreach (pal_word[i])
                pal_word[i] = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_word(int idx, logic [PAL_WORD_W-1:0] value);
            if (idx < PAL_WORDS)
                pal_word[idx] = value;
        endfunction

        function color_t entry_color(int k);
            logic [ENTRY_W-1:0] ent;
            ent = pal_word[k / ENTRIES_PER_WORD][(k % ENTRIES_PER_WORD) * ENTRY_W +: ENTRY_W];
            return color_t'(ent[14:0]);
        endfunction

        function int chan_sq(chan_t a, chan_t b);
            int d;
            d = int'(a) - int'(b);
            return d * d;
        endfunction

        // Strict compare from index 0 upward: ties keep the lowest index
        function idx_t closest_entry(color_t px);
            color_t c;
            int     cand_dist;
            int     best_dist;
            idx_t   best;
            best      = '0;
            best_dist = 0;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                c         = entry_color(k);
                cand_dist = chan_sq(px.red, c.red) + chan_sq(px.green, c.green)
                          + chan_sq(px.blue, c.blue);
                if (k == 0 || cand_dist < best_dist)
                begin
                    best      = idx_t'(k);
                    best_dist = cand_dist;
                end
            end
            return best;
        endfunction

        function void add_pair(pixel_pair_t p);
            pending_indices.push_back({closest_entry(p.odd), closest_entry(p.even)});
        endfunction

        function void check_packed(logic [7:0] got);
            logic [7:0] want;
            if (pending_indices.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %02h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_indices.pop_front();
                checked++;
                if (got !== want)
                begin
                    $display("%0t: packed_indices mismatch, expected %02h, actual %02h",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    chan_t                 even_red;
    chan_t                 even_green;
    chan_t                 even_blue;
    chan_t                 odd_red;
    chan_t                 odd_green;
    chan_t                 odd_blue;
    logic                  done;
    logic [7:0]            packed_indices;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PAL_WORD_W-1:0] pwdata;
    logic [PAL_WORD_W-1:0] prdata;
    logic                  pready;

    palette_index_checker  board;
    int                    cycle_count = 0;
    int                    gap_pct     = 0;
    int                    pairs_sent  = 0;
    int                    palettes    = 0;
    logic [ENTRY_W-1:0]    color_pool [3];

    palette_vector_quantizer #(
        .PALETTE_ENTRIES (NUM_ENTRIES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .even_red       (even_red),
        .even_green     (even_green),
        .even_blue      (even_blue),
        .odd_red        (odd_red),
        .odd_green      (odd_green),
        .odd_blue       (odd_blue),
        .done           (done),
        .packed_indices (packed_indices),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Abort on a hung pipeline
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, board.pending_indices.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check every result in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_packed(packed_indices);
    end

    function automatic logic [ENTRY_W-1:0] rgb(int r, int g, int b);
        return {1'b0, chan_t'(b), chan_t'(g), chan_t'(r)};
    endfunction

    function automatic color_t mk_color(int r, int g, int b);
        return color_t'(rgb(r, g, b));
    endfunction

    function automatic int clamp_chan(int v);
        return (v < 0) ? 0 : ((v > 31) ? 31 : v);
    endfunction

    // Mix of noise, near-palette, exact-palette and midpoint (tie-prone) colors
    function automatic color_t random_color();
        color_t a;
        color_t b;
        int     mode;
        mode = $urandom_range(9);
        a    = board.entry_color($urandom_range(NUM_ENTRIES - 1));
        b    = board.entry_color($urandom_range(NUM_ENTRIES - 1));
        if (mode < 4)
            return color_t'($urandom_range(32767));
        else if (mode < 7)
            return mk_color(clamp_chan(int'(a.red) + int'($urandom_range(4)) - 2),
                            clamp_chan(int'(a.green) + int'($urandom_range(4)) - 2),
                            clamp_chan(int'(a.blue) + int'($urandom_range(4)) - 2));
        else if (mode == 7)
            return a;
        else
            return mk_color((int'(a.red) + int'(b.red)) / 2,
                            (int'(a.green) + int'(b.green)) / 2,
                            (int'(a.blue) + int'(b.blue)) / 2);
    endfunction

    // Palette word, either free random or drawn from a small pool for ties
    function automatic logic [PAL_WORD_W-1:0] random_pal_word(bit tie_heavy);
        logic [PAL_WORD_W-1:0] w;
        for (int j = 0; j < ENTRIES_PER_WORD; j++)
            w[j * ENTRY_W +: ENTRY_W] = tie_heavy ? color_pool[$urandom_range(2)]
                                                  : ENTRY_W'($urandom());
        return w;
    endfunction

    task automatic apb_write(int idx, logic [PAL_WORD_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx * REG_STRIDE);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        board.write_word(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_palette(logic [PAL_WORD_W-1:0] w0, logic [PAL_WORD_W-1:0] w1,
                                logic [PAL_WORD_W-1:0] w2, logic [PAL_WORD_W-1:0] w3);
        apb_write(0, w0);
        apb_write(1, w1);
        apb_write(2, w2);
        apb_write(3, w3);
        palettes++;
    endtask

    // Issue one pixel pair request, then idle each cycle with gap_pct odds
    task automatic send_pair(pixel_pair_t p);
        @(negedge clk);
        start      = 1'b1;
        even_red   = p.even.red;
        even_green = p.even.green;
        even_blue  = p.even.blue;
        odd_red    = p.odd.red;
        odd_green  = p.odd.green;
        odd_blue   = p.odd.blue;
        do @(posedge clk); while (busy);
        board.add_pair(p);
        pairs_sent++;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            while ($urandom_range(99) < gap_pct)
                @(negedge clk);
        end
    endtask

    // Drop start and let the pipeline empty before touching registers
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (board.pending_indices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        color_t directed_colors [14];
        board = new();

        // Hold every input at a known value through reset
        rst_n      = 1'b0;
        start      = 1'b0;
        even_red   = '0;
        even_green = '0;
        even_blue  = '0;
        odd_red    = '0;
        odd_green  = '0;
        odd_blue   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset palette is all black: everything maps to index 0
        send_pair('{odd: mk_color(31, 31, 31), even: mk_color(0, 0, 0)});
        send_pair('{odd: mk_color(0, 0, 0), even: mk_color(31, 31, 31)});
        wait_idle();

        // Corners of the cube, duplicated entries, bit 15 set, an equidistant pair
        load_palette({rgb(0, 31, 0), rgb(31, 0, 0), rgb(31, 31, 31), rgb(0, 0, 0)},
                     {rgb(16, 16, 16), rgb(14, 14, 14), 16'h8000, rgb(0, 0, 31)},
                     {rgb(8, 8, 8), rgb(31, 0, 31), rgb(0, 31, 31), rgb(31, 31, 0)},
                     {16'hFFFF, rgb(20, 5, 25), rgb(5, 20, 10), rgb(24, 24, 24)});
        directed_colors = '{mk_color(0, 0, 0), mk_color(31, 31, 31), mk_color(31, 0, 0),
                            mk_color(0, 31, 0), mk_color(0, 0, 31), mk_color(15, 15, 15),
                            mk_color(31, 31, 0), mk_color(0, 31, 31), mk_color(31, 0, 31),
                            mk_color(5, 20, 10), mk_color(20, 5, 25), mk_color(21, 10, 21),
                            mk_color(10, 21, 10), mk_color(16, 0, 0)};
        foreach (directed_colors[i])
            send_pair('{odd: directed_colors[(i + 1) % 14], even: directed_colors[i]});
        wait_idle();

        // All-ones registers: every entry is white, ties resolve to index 0
        load_palette('1, '1, '1, '1);
        send_pair('{odd: mk_color(31, 31, 31), even: mk_color(0, 0, 0)});
        send_pair('{odd: mk_color(7, 19, 28), even: mk_color(31, 31, 31)});
        wait_idle();

        // Explicit all-zero write
        load_palette('0, '0, '0, '0);
        send_pair('{odd: mk_color(12, 3, 30), even: mk_color(31, 0, 17)});
        wait_idle();

        // Random palettes under three sender gap profiles
        for (int regime = 0; regime < 3; regime++)
        begin
            gap_pct = (regime == 0) ? 8 : ((regime == 1) ? 79 : 0);
            for (int pal = 0; pal < 2; pal++)
            begin
                foreach (color_pool[i])
                    color_pool[i] = ENTRY_W'($urandom());
                load_palette(random_pal_word(pal == 1), random_pal_word(pal == 1),
                             random_pal_word(pal == 1), random_pal_word(pal == 1));
                for (int n = 0; n < PAIRS_PER_PALETTE; n++)
                    send_pair('{odd: random_color(), even: random_color()});
                wait_idle();
            end
        end

        if (board.pending_indices.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, board.pending_indices.size());
            board.mismatches++;
        end

        $display("Quantized %0d pixel pairs (%0d results checked) across %0d palette loads,",
                 pairs_sent, board.checked, palettes);
        $display("with the sender idle from none to about 79 percent of cycles.");
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ palette_vector_quantizer.f @@
hdl/pvq_pkg.sv
hdl/pvq_dist.sv
hdl/pvq_argmin.sv
hdl/palette_vector_quantizer.sv
hdl/pvq_checker.sv
verif/palette_vector_quantizer_tb.sv
